[hw/rtl/slot_index_allocator_assert.svh]
// Assertion macros shared by the allocator RTL.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef SLOT_INDEX_ALLOCATOR_ASSERT_SVH
`define SLOT_INDEX_ALLOCATOR_ASSERT_SVH

`define SIA_ASSERT_HOLD(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`define SIA_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[hw/rtl/sia_pkg.sv]
`timescale 1ns / 1ps

package sia_pkg;

	localparam int KIND_W   = 1;
	localparam int IDX_W    = 10;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 8;
	localparam int COUNT_W  = 9;

	localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
	localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_FREE  = 2'd3
	} status_t;

endpackage

[hw/rtl/sia_req_if.sv]
`timescale 1ns / 1ps

interface sia_req_if import sia_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [IDX_W-1:0]  slot_to_free;

	modport source (output valid, output kind, output slot_to_free, input ready);
	modport sink (input valid, input kind, input slot_to_free, output ready);
endinterface

[hw/rtl/sia_rsp_if.sv]
`timescale 1ns / 1ps

interface sia_rsp_if import sia_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;
	logic [COUNT_W-1:0]  used_count;
	logic [COUNT_W-1:0]  high_water;

	modport source (
		output valid, output status, output slot, output used_count, output high_water,
		input ready
	);
	modport sink (
		input valid, input status, input slot, input used_count, input high_water,
		output ready
	);
endinterface

[hw/rtl/slot_index_allocator.sv]
// Slot allocator for a pool of SLOTS slots. Each request beat on req (allocate, or free
// slot_to_free) produces exactly one response beat on rsp carrying the status, the
// allocated slot, the used count and the high-water mark. Free slots sit in a LIFO
// stack memory and the in-use bits in a second memory; both are read when a request
// is accepted and written back when its result is loaded into the response register,
// which waits while the previous response is not yet taken. No new request is accepted
// until then. The response register lets a new request be accepted while the previous
// response waits. No clearing pass is needed after reset: stack entries and in-use bits
// that were never written are recognized from the stack depth and the high-water mark.
`timescale 1ns / 1ps
`include "slot_index_allocator_assert.svh"

module slot_index_allocator import sia_pkg::*; #(
	parameter int SLOTS = 256
) (
	input logic        clk,
	input logic        arst_n,
	sia_req_if.sink    req,
	sia_rsp_if.source  rsp
);

	localparam int SW  = $clog2(SLOTS);
	localparam int CW  = $clog2(SLOTS + 1);
	localparam int XW  = CW + 1;
	localparam int IW  = (IDX_W > CW) ? IDX_W + 1 : CW + 1;
	localparam int OSW = (SW > SLOT_W) ? SW : SLOT_W;
	localparam int OCW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

	logic [SW-1:0] stack_mem [SLOTS];
	logic          in_use_mem [SLOTS];

	logic [SW-1:0] stack_rd_s1;
	logic          in_use_rd_s1;
	logic          busy_s1;
	logic          free_s1;
	logic [SW-1:0] idx_s1;
	logic          range_bad_s1;

	logic [CW-1:0] top_q;
	logic [CW-1:0] used_q;
	logic [CW-1:0] hm_q;

	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [COUNT_W-1:0]  used_out_q;
	logic [COUNT_W-1:0]  hw_out_q;

	logic          accept;
	logic          done;
	logic [SW-1:0] stack_rd_addr;
	logic          stack_fresh;
	logic [SW-1:0] pop_slot;
	logic          slot_used;
	logic          pop_ok;
	logic          free_ok;
	status_t       status_d;
	logic [SW-1:0] slot_d;
	logic [CW-1:0] top_d;
	logic [CW-1:0] used_d;
	logic [CW-1:0] hm_d;
	logic [CW-1:0] pop_mark;
	logic          stack_we;
	logic          use_we;
	logic [SW-1:0] use_addr;
	logic [OSW-1:0] slot_wide;
	logic [OCW-1:0] used_wide;
	logic [OCW-1:0] hm_wide;

	assign req.ready     = !busy_s1;
	assign accept        = req.valid && req.ready;
	assign done          = busy_s1 && (!rsp_valid_q || rsp.ready);
	assign stack_rd_addr = SW'(top_q - CW'(1));

	always_comb begin
		stack_fresh = (XW'(top_q) + XW'(hm_q)) <= XW'(SLOTS);
		pop_slot    = stack_fresh ? SW'(SLOTS_C - top_q) : stack_rd_s1;
		pop_mark    = CW'(pop_slot) + CW'(1);
		slot_used   = (CW'(idx_s1) < hm_q) && in_use_rd_s1;
		pop_ok      = !free_s1 && (used_q < SLOTS_C) && (top_q != '0)
			&& (CW'(pop_slot) < SLOTS_C);
		free_ok     = free_s1 && !range_bad_s1 && slot_used && (top_q < SLOTS_C);

		status_d = ST_OK;
		slot_d   = '0;
		top_d    = top_q;
		used_d   = used_q;
		hm_d     = hm_q;
		if (!free_s1) begin
			if (pop_ok) begin
				slot_d = pop_slot;
				top_d  = top_q - CW'(1);
				used_d = used_q + CW'(1);
				if (pop_mark > hm_q) begin
					hm_d = pop_mark;
				end
			end else begin
				status_d = ST_FULL;
			end
		end else if (range_bad_s1) begin
			status_d = ST_RANGE;
		end else if (free_ok) begin
			top_d = top_q + CW'(1);
			if (used_q != '0) begin
				used_d = used_q - CW'(1);
			end
		end else begin
			status_d = ST_FREE;
		end

		stack_we  = done && free_ok;
		use_we    = done && (pop_ok || free_ok);
		use_addr  = pop_ok ? pop_slot : idx_s1;
		slot_wide = OSW'(slot_d);
		used_wide = OCW'(used_d);
		hm_wide   = OCW'(hm_d);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stack_rd_s1  <= stack_mem[stack_rd_addr];
			in_use_rd_s1 <= in_use_mem[req.slot_to_free[SW-1:0]];
		end
		if (stack_we) begin
			stack_mem[SW'(top_q)] <= idx_s1;
		end
		if (use_we) begin
			in_use_mem[use_addr] <= pop_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			free_s1      <= (req.kind == KIND_FREE);
			idx_s1       <= req.slot_to_free[SW-1:0];
			range_bad_s1 <= IW'(req.slot_to_free) >= IW'(SLOTS);
		end
		if (done) begin
			status_q   <= status_d;
			slot_q     <= slot_wide[SLOT_W-1:0];
			used_out_q <= used_wide[COUNT_W-1:0];
			hw_out_q   <= hm_wide[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
			top_q       <= SLOTS_C;
			used_q      <= '0;
			hm_q        <= '0;
		end else begin
			if (accept) begin
				busy_s1 <= 1'b1;
			end else if (done) begin
				busy_s1 <= 1'b0;
			end
			if (done) begin
				rsp_valid_q <= 1'b1;
				top_q       <= top_d;
				used_q      <= used_d;
				hm_q        <= hm_d;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.slot       = slot_q;
	assign rsp.used_count = used_out_q;
	assign rsp.high_water = hw_out_q;

	`SIA_ASSERT_HOLD(a_count_sum, (XW'(top_q) + XW'(used_q)) == XW'(SLOTS), "stack depth and used count disagree")
	`SIA_ASSERT_HOLD(a_top_mark, (XW'(top_q) + XW'(hm_q)) >= XW'(SLOTS), "stack depth below high-water bound")
	`SIA_ASSERT_NEXT(a_accept_busy, accept, busy_s1, "accepted beat not held")
	`SIA_ASSERT_NEXT(a_done_valid, done, rsp_valid_q && !busy_s1, "finished beat not presented")

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import sia_pkg::*;

	localparam int POOL_SLOTS = 256;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [COUNT_W-1:0]  used_count;
		logic [COUNT_W-1:0]  high_water;
	} alloc_response_t;

	class slot_pool_scoreboard;
		logic [SLOT_W-1:0] free_stack[POOL_SLOTS];
		int unsigned       stack_depth;
		bit                in_use[POOL_SLOTS];
		int unsigned       used_slots;
		int unsigned       high_mark;
		alloc_response_t   pending_responses[$];
		int unsigned       mismatches;

		function new();
			for (int i = 0; i < POOL_SLOTS; i++) begin
				free_stack[i] = SLOT_W'(POOL_SLOTS - 1 - i);
				in_use[i] = 1'b0;
			end
			stack_depth = POOL_SLOTS;
			used_slots = 0;
			high_mark = 0;
			mismatches = 0;
		endfunction

		function void take_request(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx);
			alloc_response_t r;
			int unsigned s;
			r.slot = '0;
			if (kind == KIND_ALLOC) begin
				if (used_slots >= POOL_SLOTS || stack_depth == 0) begin
					r.status = ST_FULL;
				end else begin
					s = free_stack[stack_depth - 1];
					stack_depth--;
					if (s + 1 > high_mark) begin
						high_mark = s + 1;
					end
					in_use[s] = 1'b1;
					used_slots++;
					r.status = ST_OK;
					r.slot = SLOT_W'(s);
				end
			end else if (idx >= POOL_SLOTS) begin
				r.status = ST_RANGE;
			end else if (!in_use[idx] || stack_depth >= POOL_SLOTS) begin
				r.status = ST_FREE;
			end else begin
				in_use[idx] = 1'b0;
				free_stack[stack_depth] = SLOT_W'(idx);
				stack_depth++;
				if (used_slots > 0) begin
					used_slots--;
				end
				r.status = ST_OK;
			end
			r.used_count = COUNT_W'(used_slots);
			r.high_water = COUNT_W'(high_mark);
			pending_responses.push_back(r);
		endfunction

		function void check_response(alloc_response_t got);
			alloc_response_t exp;
			if (pending_responses.size() == 0) begin
				$display("%0t: unexpected response status=%0d slot=%0d used=%0d high=%0d",
					$time, got.status, got.slot, got.used_count, got.high_water);
				mismatches++;
				return;
			end
			exp = pending_responses.pop_front();
			if (got.status !== exp.status || got.slot !== exp.slot
					|| got.used_count !== exp.used_count || got.high_water !== exp.high_water) begin
				$display("%0t: mismatch expected status=%0d slot=%0d used=%0d high=%0d",
					$time, exp.status, exp.slot, exp.used_count, exp.high_water);
				$display("%0t:          actual   status=%0d slot=%0d used=%0d high=%0d",
					$time, got.status, got.slot, got.used_count, got.high_water);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sia_req_if req_ch();
	sia_rsp_if rsp_ch();

	slot_index_allocator #(.SLOTS(POOL_SLOTS)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	slot_pool_scoreboard sb = new();

	int sender_idle_pct = 26;
	int receiver_idle_pct = 82;
	bit hold_off = 1'b0;
	bit filling = 1'b1;
	int unsigned accepted_requests = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				sb.take_request(req_ch.kind, req_ch.slot_to_free);
				accepted_requests++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				sb.check_response({rsp_ch.status, rsp_ch.slot, rsp_ch.used_count,
					rsp_ch.high_water});
			end
		end
	end

	always @(negedge clk) begin
		rsp_ch.ready <= !hold_off && ($urandom_range(0, 99) >= receiver_idle_pct);
	end

	// Long receiver stall in the idle-free phase so the request side backs up.
	initial begin
		wait (accepted_requests >= 1000);
		hold_off = 1'b1;
		repeat (80) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("FAIL slot_index_allocator");
		$finish;
	end

	task automatic send_request(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.slot_to_free <= idx;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// Alternates between filling the pool up to full and draining it back to empty.
	task automatic run_random(input int count);
		int roll;
		int start;
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0] idx;
		for (int n = 0; n < count; n++) begin
			if (sb.used_slots == POOL_SLOTS && $urandom_range(0, 3) == 0) begin
				filling = 1'b0;
			end
			if (sb.used_slots == 0 && $urandom_range(0, 3) == 0) begin
				filling = 1'b1;
			end
			roll = $urandom_range(0, 99);
			idx = IDX_W'($urandom_range(0, 1023));
			if (roll < 6) begin
				kind = $urandom_range(0, 1) ? KIND_FREE : KIND_ALLOC;
			end else if (roll < (filling ? 86 : 16) || sb.used_slots == 0) begin
				kind = KIND_ALLOC;
			end else begin
				kind = KIND_FREE;
				start = $urandom_range(0, POOL_SLOTS - 1);
				for (int i = 0; i < POOL_SLOTS; i++) begin
					if (sb.in_use[(start + i) % POOL_SLOTS]) begin
						idx = IDX_W'((start + i) % POOL_SLOTS);
						break;
					end
				end
			end
			send_request(kind, idx);
		end
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_ALLOC;
		req_ch.slot_to_free = '0;
		rsp_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_request(KIND_ALLOC, 10'd1023);
		send_request(KIND_ALLOC, 10'd0);
		send_request(KIND_FREE, 10'd0);
		send_request(KIND_FREE, 10'd0);
		send_request(KIND_ALLOC, 10'd682);
		send_request(KIND_FREE, 10'd256);
		send_request(KIND_FREE, 10'd1023);
		send_request(KIND_FREE, 10'd512);
		send_request(KIND_FREE, 10'd255);
		send_request(KIND_ALLOC, 10'd341);
		send_request(KIND_FREE, 10'd1);
		send_request(KIND_FREE, 10'd0);
		send_request(KIND_FREE, 10'd2);
		send_request(KIND_FREE, 10'd2);
		send_request(KIND_ALLOC, 10'd0);

		run_random(400);
		sender_idle_pct = 82;
		receiver_idle_pct = 26;
		run_random(400);
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		run_random(400);
		req_ch.valid <= 1'b0;

		while (sb.pending_responses.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("PASS slot_index_allocator");
		end else begin
			$display("FAIL slot_index_allocator");
		end
		$finish;
	end

endmodule

[slot_index_allocator.f]
+incdir+hw/rtl
hw/rtl/sia_pkg.sv
hw/rtl/sia_req_if.sv
hw/rtl/sia_rsp_if.sv
hw/rtl/slot_index_allocator.sv
tb/sv/testbench.sv
